[sv/dxs_pkg.sv]
package dxs_pkg;

    // Filter lanes: one per surface channel, at most four are ever read
    localparam int CHANNELS  = 4;
    localparam int NUM_AXES  = 4;
    localparam int NUM_LANES = (CHANNELS < NUM_AXES) ? CHANNELS : NUM_AXES;

    typedef logic signed [15:0] q14_t;

    // Configuration register indexes
    localparam logic [2:0] REG_AXIS_SELECT = 3'd0;
    localparam logic [2:0] REG_WARMUP_MS   = 3'd1;
    localparam logic [2:0] REG_TRIM_SPEED  = 3'd2;
    localparam logic [2:0] REG_AMP_FIRST   = 3'd3;
    localparam logic [2:0] REG_AMP_SECOND  = 3'd4;
    localparam logic [2:0] REG_AMP_THIRD   = 3'd5;
    localparam logic [2:0] REG_SECOND_MS   = 3'd6;

    // Excited axis codes; the spare code falls back to rudder
    localparam logic [1:0] AXIS_RUDDER   = 2'd0;
    localparam logic [1:0] AXIS_AILERON  = 2'd1;
    localparam logic [1:0] AXIS_ELEVATOR = 2'd2;

    // Schedule boundaries in ms, relative to warmup
    localparam logic [24:0] T_OVERRIDE = 25'd9500;
    localparam logic [24:0] T_P1_START = 25'd10000;
    localparam logic [24:0] T_P1_END   = 25'd10200;
    localparam logic [24:0] T_P2_START = 25'd12000;
    localparam logic [24:0] T_P3_START = 25'd14000;
    localparam logic [24:0] T_P3_END   = 25'd14200;

    // Low-pass coefficients, Q2.30
    localparam logic signed [31:0] COEF_B1 = 32'sd212047;
    localparam logic signed [31:0] COEF_B2 = 32'sd209378;
    localparam logic signed [31:0] COEF_A1 = -32'sd2107025549;
    localparam logic signed [31:0] COEF_A2 = 32'sd1033705149;

    localparam logic signed [63:0] ROUND_Q24 = 64'sd536870912;
    localparam logic signed [63:0] Y_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] Y_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic [1:0]  axis_select;
        logic [15:0] warmup_ms;
        logic [7:0]  trim_speed;
        q14_t        amp_first;
        q14_t        amp_second;
        q14_t        amp_third;
        logic [10:0] second_pulse_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        axis_select:     2'd0,
        warmup_ms:       16'd0,
        trim_speed:      8'd23,
        amp_first:       -16'sd4575,
        amp_second:      16'sd10294,
        amp_third:       -16'sd2860,
        second_pulse_ms: 11'd400
    };

    typedef struct packed {
        logic       hold_loop;
        logic [7:0] speed_cmd;
        logic       override;
        q14_t       aileron_right;
        q14_t       aileron_left;
        q14_t       elevator_out;
        q14_t       rudder_out;
        q14_t       throttle_out;
        logic       pulse_active;
    } res_t;

    function automatic q14_t neg_sat16(q14_t v);
        q14_t r;
        if (v == -16'sd32768)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

endpackage

[sv/dxs_iir_lane.sv]
module dxs_iir_lane
    import dxs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  q14_t u_in,
    output q14_t trim
);

    // p_reg carries the part of the next sum that does not need the newest
    // output: B1*u[n-1] + B2*u[n-2] (scaled) - A2*y[n-2].
    q14_t               u1_reg;
    logic signed [31:0] y1_reg;
    logic signed [63:0] p_reg;

    logic signed [31:0] y_next;
    logic signed [63:0] p_next;
    logic signed [63:0] prod_a1;
    logic signed [63:0] acc;
    logic signed [63:0] acc_rnd;
    logic signed [63:0] y_wide;
    logic signed [63:0] b_sum;
    logic signed [32:0] trim_wide;
    logic signed [32:0] trim_sh;

    always_comb
    begin
        prod_a1 = 64'(COEF_A1) * 64'(y1_reg);
        acc     = p_reg - prod_a1;
        acc_rnd = acc + ROUND_Q24;
        y_wide  = acc_rnd >>> 30;
        if (y_wide > Y_MAX)
        begin
            y_next = 32'sh7FFFFFFF;
        end
        else if (y_wide < Y_MIN)
        begin
            y_next = -32'sh80000000;
        end
        else
        begin
            y_next = y_wide[31:0];
        end

        // Prepare the input and y[n-1] terms for the following step
        b_sum  = 64'(COEF_B1) * 64'(u_in) + 64'(COEF_B2) * 64'(u1_reg);
        p_next = (b_sum <<< 10) - 64'(COEF_A2) * 64'(y1_reg);

        // Q8.24 down to Q2.14, round half up, saturate
        trim_wide = 33'(y1_reg) + 33'sd512;
        trim_sh   = trim_wide >>> 10;
        if (trim_sh > 33'sd32767)
        begin
            trim = 16'sd32767;
        end
        else if (trim_sh < -33'sd32768)
        begin
            trim = -16'sd32768;
        end
        else
        begin
            trim = trim_sh[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u1_reg <= '0;
            y1_reg <= '0;
            p_reg  <= '0;
        end
        else if (step)
        begin
            u1_reg <= u_in;
            y1_reg <= y_next;
            p_reg  <= p_next;
        end
    end

endmodule

[sv/dxs_sched.sv]
module dxs_sched
    import dxs_pkg::*;
(
    input  logic [23:0] time_ms,
    input  cfg_t        cfg,
    input  q14_t        trim [NUM_AXES],
    output logic        step,
    output res_t        res
);

    logic [24:0] t_ext;
    logic [24:0] w_ext;
    logic        hold;
    logic        win1;
    logic        win2;
    logic        win3;
    q14_t        amp;

    always_comb
    begin
        t_ext = 25'(time_ms);
        w_ext = 25'(cfg.warmup_ms);
        hold  = t_ext < (w_ext + T_OVERRIDE);
        step  = hold && (t_ext >= w_ext);

        win1 = (t_ext >= w_ext + T_P1_START) && (t_ext < w_ext + T_P1_END);
        win2 = (t_ext >= w_ext + T_P2_START)
            && (t_ext < w_ext + T_P2_START + 25'(cfg.second_pulse_ms));
        win3 = (t_ext >= w_ext + T_P3_START) && (t_ext < w_ext + T_P3_END);

        // Later window wins where they overlap
        priority if (win3)
        begin
            amp = cfg.amp_third;
        end
        else if (win2)
        begin
            amp = cfg.amp_second;
        end
        else
        begin
            amp = cfg.amp_first;
        end

        res = '0;
        if (hold)
        begin
            res.hold_loop = 1'b1;
            res.speed_cmd = cfg.trim_speed;
        end
        else
        begin
            res.override      = 1'b1;
            res.aileron_right = trim[0];
            res.elevator_out  = trim[1];
            res.rudder_out    = trim[2];
            res.throttle_out  = trim[3];
            if (win1 || win2 || win3)
            begin
                res.pulse_active = 1'b1;
                unique case (cfg.axis_select)
                    AXIS_AILERON:  res.aileron_right = amp;
                    AXIS_ELEVATOR: res.elevator_out  = amp;
                    AXIS_RUDDER:   res.rudder_out    = amp;
                    default:       res.rudder_out    = amp;
                endcase
            end
            res.aileron_left = neg_sat16(res.aileron_right);
        end
    end

endmodule

[sv/doublet_excitation_sequencer_unit.sv]
// Doublet excitation sequencer with trim estimation.
// Input channel: in_valid/in_stall carry one control frame per beat (time in
// ms plus aileron, elevator, rudder and throttle commands, Q2.14).
// Output channel: out_valid/out_stall carry one result beat per frame (hold
// and override flags, speed command, five surface outputs, pulse flag).
// Config port: cfg_we/cfg_index/cfg_data, to be written only while no frame is
// in flight; the block does not enforce it. Frames move from input register to
// result register. Throughput: one frame per clock while out_stall is low, no
// bubbles. For a frame between warmup and override the filter update (two 32x32
// and two 32x16 products and a few 64-bit adds per channel) completes in the same
// cycle that the frame moves to the output register. When out_stall is high the
// result register holds and the input register fills; in_stall rises only once
// both are occupied. Reset clears both pipeline valids, loads the register
// defaults (rudder axis, zero warmup, speed 23, default amplitudes, 400 ms second
// pulse) and zeroes the filter history, so all trim estimates start at zero.
module doublet_excitation_sequencer_unit
    import dxs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] time_ms,
    input  q14_t        aileron_in,
    input  q14_t        elevator_in,
    input  q14_t        rudder_in,
    input  q14_t        throttle_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        hold_loop,
    output logic [7:0]  speed_cmd,
    output logic        override,
    output q14_t        aileron_right,
    output q14_t        aileron_left,
    output q14_t        elevator_out,
    output q14_t        rudder_out,
    output q14_t        throttle_out,
    output logic        pulse_active
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [23:0] a_time_reg;
    q14_t        a_cmd_reg [NUM_AXES];

    logic        out_valid_reg;
    logic        out_valid_next;
    res_t        res_reg;

    logic        advance;
    logic        fire_a;
    logic        in_accept;
    logic        sched_step;
    logic        lane_step;
    res_t        sched_res;
    q14_t        trim [NUM_AXES];

    // Config writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AXIS_SELECT: cfg_next.axis_select     = cfg_data[1:0];
                REG_WARMUP_MS:   cfg_next.warmup_ms       = cfg_data;
                REG_TRIM_SPEED:  cfg_next.trim_speed      = cfg_data[7:0];
                REG_AMP_FIRST:   cfg_next.amp_first       = cfg_data;
                REG_AMP_SECOND:  cfg_next.amp_second      = cfg_data;
                REG_AMP_THIRD:   cfg_next.amp_third       = cfg_data;
                REG_SECOND_MS:   cfg_next.second_pulse_ms = cfg_data[10:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Two-register pipeline: input register, then result register
    always_comb
    begin
        advance   = !out_valid_reg || !out_stall;
        fire_a    = a_valid_reg && advance;
        in_stall  = a_valid_reg && !advance;
        in_accept = in_valid && !in_stall;

        a_valid_next = a_valid_reg;
        if (in_accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (fire_a)
        begin
            a_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = a_valid_reg;
        end

        lane_step = fire_a && sched_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_time_reg   <= time_ms;
            a_cmd_reg[0] <= aileron_in;
            a_cmd_reg[1] <= elevator_in;
            a_cmd_reg[2] <= rudder_in;
            a_cmd_reg[3] <= throttle_in;
        end
        if (fire_a)
        begin
            res_reg <= sched_res;
        end
    end

    for (genvar c = 0; c < NUM_AXES; c++)
    begin : g_lane
        if (c < NUM_LANES)
        begin : g_on
            dxs_iir_lane u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .step  (lane_step),
                .u_in  (a_cmd_reg[c]),
                .trim  (trim[c])
            );
        end
        else
        begin : g_off
            assign trim[c] = '0;
        end
    end

    dxs_sched u_sched (
        .time_ms (a_time_reg),
        .cfg     (cfg_reg),
        .trim    (trim),
        .step    (sched_step),
        .res     (sched_res)
    );

    assign out_valid     = out_valid_reg;
    assign hold_loop     = res_reg.hold_loop;
    assign speed_cmd     = res_reg.speed_cmd;
    assign override      = res_reg.override;
    assign aileron_right = res_reg.aileron_right;
    assign aileron_left  = res_reg.aileron_left;
    assign elevator_out  = res_reg.elevator_out;
    assign rudder_out    = res_reg.rudder_out;
    assign throttle_out  = res_reg.throttle_out;
    assign pulse_active  = res_reg.pulse_active;

`ifndef NO_ASSERTIONS
    a_hold_zero_surfaces: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !override |-> aileron_right == 16'sd0 && aileron_left == 16'sd0
            && elevator_out == 16'sd0 && rudder_out == 16'sd0 && throttle_out == 16'sd0)
        else $error("surface output nonzero outside override");

    a_pulse_in_override: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pulse_active |-> override && !hold_loop && speed_cmd == 8'd0)
        else $error("pulse flagged outside override phase");

    a_left_mirrors_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && override |-> aileron_left == neg_sat16(aileron_right))
        else $error("left aileron is not the negated right aileron");

    a_filter_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !lane_step |=> $stable(trim[0]))
        else $error("trim estimate moved without a filter step");
`endif

endmodule
